// ===== design/mcis_pkg.sv =====
// ============================================================================
// mcis_pkg - shared types and constants for the mip chain size block
// Field widths, the sequencer state type and the result limit.
// ============================================================================
package mcis_pkg;

    localparam int DIM_W   = 16;  // base width / height / layers
    localparam int LVL_W   = 6;   // level count
    localparam int BLK_W   = 5;   // block width / height
    localparam int BYTES_W = 6;   // bytes per block
    localparam int TOTAL_W = 54;  // result width
    localparam int K_W     = DIM_W + BYTES_W;     // layers * bytes per block
    localparam int NXY_W   = 2 * DIM_W;           // blocks per level
    localparam int MULA_W  = NXY_W;               // shared multiplier, operand a
    localparam int MULB_W  = K_W;                 // shared multiplier, operand b
    localparam int PROD_W  = MULA_W + MULB_W;     // shared multiplier, product
    localparam int ACC_W   = TOTAL_W + LVL_W;     // room for 63 full-size levels
    localparam int CNT_W   = 4;                   // divider bit counter
    localparam int LVL_LOOP = 16;                 // levels from this one up are all 1x1

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KMUL,
        S_DIVX,
        S_DIVY,
        S_DIMS,
        S_MXY,
        S_MTERM,
        S_TAIL
    } t_state;

endpackage

// ===== design/mcis_if.sv =====
// ============================================================================
// mcis_if - valid/ready channels of the mip chain size block
// Request channel carries one image description, result channel the size.
// ============================================================================
interface mcis_in_if;
    logic                          valid;
    logic                          ready;
    logic [mcis_pkg::DIM_W-1:0]    base_width;
    logic [mcis_pkg::DIM_W-1:0]    base_height;
    logic [mcis_pkg::LVL_W-1:0]    level_count;
    logic [mcis_pkg::DIM_W-1:0]    layers;
    logic [mcis_pkg::BLK_W-1:0]    block_w;
    logic [mcis_pkg::BLK_W-1:0]    block_h;
    logic [mcis_pkg::BYTES_W-1:0]  block_bytes;

    modport source (
        output valid, base_width, base_height, level_count, layers,
               block_w, block_h, block_bytes,
        input  ready
    );
    modport sink (
        input  valid, base_width, base_height, level_count, layers,
               block_w, block_h, block_bytes,
        output ready
    );
endinterface

interface mcis_out_if;
    logic                          valid;
    logic                          ready;
    logic [mcis_pkg::TOTAL_W-1:0]  total_bytes;

    modport source (output valid, total_bytes, input ready);
    modport sink   (input valid, total_bytes, output ready);
endinterface

// ===== design/mip_chain_image_size.sv =====
// ============================================================================
// mip_chain_image_size - total byte size of a texture mip chain
// Sums block count * bytes per block * layers over all requested mip levels.
// ============================================================================
// One request transaction is taken while the sequencer is idle; the block
// then stays busy until the size is computed. A request runs through one
// step for layers*bytes, the two bit-serial block divisions of the base
// width and height, then three steps per level (set up block counts,
// blocks_x*blocks_y, times layers*bytes) on the one shared multiplier,
// and one closing step. Levels 16 and up are 1x1 and are folded into a
// single multiply by the remaining level count. The result sits in an
// output register, so the next request is taken while the previous size
// waits on o_out; the closing step waits only if that register is still
// full. Block sizes of 0 count as 1; a total above 2^54-1 saturates.
// ============================================================================
module mip_chain_image_size (
    input  logic i_clk,
    input  logic i_rst_n,
    mcis_in_if.sink    i_in,
    mcis_out_if.source o_out
);

    // ---------------- registers ----------------
    mcis_pkg::t_state                r_state,  n_state;
    logic [mcis_pkg::CNT_W-1:0]      r_cnt,    n_cnt;     // division bit
    logic [mcis_pkg::LVL_W-1:0]      r_lvl,    n_lvl;     // current mip level
    logic                            r_pend,   n_pend;    // product waits for add
    logic                            r_ovld,   n_ovld;    // output register full

    logic [mcis_pkg::DIM_W-1:0]      r_bw, n_bw, r_bh, n_bh, r_layers, n_layers;
    logic [mcis_pkg::LVL_W-1:0]      r_levels, n_levels;
    logic [mcis_pkg::BLK_W-1:0]      r_blkw, n_blkw, r_blkh, n_blkh;
    logic [mcis_pkg::BYTES_W-1:0]    r_bytes, n_bytes;
    logic [mcis_pkg::DIM_W-1:0]      r_quo, n_quo;        // divider shift reg
    logic [mcis_pkg::BLK_W-1:0]      r_rem, n_rem;        // divider remainder
    logic [mcis_pkg::DIM_W-1:0]      r_qx, n_qx, r_qy, n_qy; // width/blk, height/blk
    logic [mcis_pkg::K_W-1:0]        r_k, n_k;            // layers * bytes
    logic [mcis_pkg::DIM_W-1:0]      r_nx, n_nx, r_ny, n_ny;
    logic [mcis_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [mcis_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [mcis_pkg::TOTAL_W-1:0]    r_total, n_total;

    // ---------------- shared multiplier ----------------
    logic [mcis_pkg::MULA_W-1:0]     mul_a;
    logic [mcis_pkg::MULB_W-1:0]     mul_b;
    logic [mcis_pkg::PROD_W-1:0]     mul_p;

    assign mul_p = {{mcis_pkg::MULB_W{1'b0}}, mul_a} * {{mcis_pkg::MULA_W{1'b0}}, mul_b};

    // operand select by sequencer state
    always_comb begin
        case (r_state)
            mcis_pkg::S_MXY: begin
                mul_a = {{(mcis_pkg::MULA_W-mcis_pkg::DIM_W){1'b0}}, r_nx};
                mul_b = {{(mcis_pkg::MULB_W-mcis_pkg::DIM_W){1'b0}}, r_ny};
            end
            mcis_pkg::S_MTERM: begin
                mul_a = r_prod[mcis_pkg::MULA_W-1:0];
                mul_b = r_k;
            end
            mcis_pkg::S_TAIL: begin
                mul_a = {{(mcis_pkg::MULA_W-mcis_pkg::K_W){1'b0}}, r_k};
                mul_b = {{(mcis_pkg::MULB_W-mcis_pkg::LVL_W){1'b0}}, lvl_left};
            end
            default: begin
                mul_a = {{(mcis_pkg::MULA_W-mcis_pkg::DIM_W){1'b0}}, r_layers};
                mul_b = {{(mcis_pkg::MULB_W-mcis_pkg::BYTES_W){1'b0}}, r_bytes};
            end
        endcase
    end

    // ---------------- divider step ----------------
    // restoring division, one quotient bit per cycle
    logic [mcis_pkg::BLK_W-1:0]      div_d;
    logic [mcis_pkg::BLK_W:0]        div_t;
    logic [mcis_pkg::BLK_W:0]        div_s;
    logic                            div_ge;

    assign div_d  = (r_state == mcis_pkg::S_DIVY) ? r_blkh : r_blkw;
    assign div_t  = {r_rem, r_quo[mcis_pkg::DIM_W-1]};
    assign div_ge = div_t >= {1'b0, div_d};
    assign div_s  = div_t - {1'b0, div_d};

    // ---------------- per-level block counts ----------------
    // ceil(y/b) = (q >> i) + 1 when y is not a multiple of b; q = base/b.
    // A dimension that shifted down to 0 is clamped to 1 texel: one block.
    logic [3:0]                      lvl_sh;
    logic [mcis_pkg::DIM_W-1:0]      x_dim, y_dim, x_q, y_q;
    logic [mcis_pkg::DIM_W+mcis_pkg::BLK_W-1:0] x_back, y_back;
    logic [mcis_pkg::DIM_W:0]        x_cnt, y_cnt;
    logic [mcis_pkg::DIM_W-1:0]      x_blk, y_blk;

    assign lvl_sh = r_lvl[3:0];
    assign x_dim  = r_bw >> lvl_sh;
    assign y_dim  = r_bh >> lvl_sh;
    assign x_q    = r_qx >> lvl_sh;
    assign y_q    = r_qy >> lvl_sh;
    assign x_back = {{mcis_pkg::BLK_W{1'b0}}, x_q} * {{mcis_pkg::DIM_W{1'b0}}, r_blkw};
    assign y_back = {{mcis_pkg::BLK_W{1'b0}}, y_q} * {{mcis_pkg::DIM_W{1'b0}}, r_blkh};
    assign x_cnt  = {1'b0, x_q} + {{mcis_pkg::DIM_W{1'b0}},
                    (x_back != {{mcis_pkg::BLK_W{1'b0}}, x_dim})};
    assign y_cnt  = {1'b0, y_q} + {{mcis_pkg::DIM_W{1'b0}},
                    (y_back != {{mcis_pkg::BLK_W{1'b0}}, y_dim})};
    assign x_blk  = (x_dim == '0) ? mcis_pkg::DIM_W'(1) : x_cnt[mcis_pkg::DIM_W-1:0];
    assign y_blk  = (y_dim == '0) ? mcis_pkg::DIM_W'(1) : y_cnt[mcis_pkg::DIM_W-1:0];

    // ---------------- accumulate and saturate ----------------
    logic [mcis_pkg::ACC_W-1:0]      acc_sum;
    logic [mcis_pkg::TOTAL_W-1:0]    acc_sat;
    logic [mcis_pkg::LVL_W-1:0]      lvl_left;

    assign acc_sum  = r_acc + (r_pend ? {{(mcis_pkg::ACC_W-mcis_pkg::PROD_W){1'b0}}, r_prod}
                                      : '0);
    assign acc_sat  = (acc_sum[mcis_pkg::ACC_W-1:mcis_pkg::TOTAL_W] != '0)
                    ? mcis_pkg::TOTAL_MAX : acc_sum[mcis_pkg::TOTAL_W-1:0];
    assign lvl_left = r_levels - r_lvl;

    // ---------------- handshake ----------------
    assign i_in.ready        = (r_state == mcis_pkg::S_IDLE);
    assign o_out.valid       = r_ovld;
    assign o_out.total_bytes = r_total;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_lvl    = r_lvl;
        n_pend   = r_pend;
        n_ovld   = r_ovld & ~o_out.ready;
        n_bw     = r_bw;
        n_bh     = r_bh;
        n_levels = r_levels;
        n_layers = r_layers;
        n_blkw   = r_blkw;
        n_blkh   = r_blkh;
        n_bytes  = r_bytes;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_k      = r_k;
        n_nx     = r_nx;
        n_ny     = r_ny;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_total  = r_total;

        case (r_state)
            mcis_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_bw     = i_in.base_width;
                    n_bh     = i_in.base_height;
                    n_levels = i_in.level_count;
                    n_layers = i_in.layers;
                    n_blkw   = (i_in.block_w == '0) ? mcis_pkg::BLK_W'(1) : i_in.block_w;
                    n_blkh   = (i_in.block_h == '0) ? mcis_pkg::BLK_W'(1) : i_in.block_h;
                    n_bytes  = i_in.block_bytes;
                    n_quo    = i_in.base_width;
                    n_rem    = '0;
                    n_state  = mcis_pkg::S_KMUL;
                end
            end

            mcis_pkg::S_KMUL: begin
                n_prod  = mul_p;
                n_cnt   = '0;
                n_state = mcis_pkg::S_DIVX;
            end

            mcis_pkg::S_DIVX, mcis_pkg::S_DIVY: begin
                if (r_state == mcis_pkg::S_DIVX && r_cnt == '0) begin
                    n_k = r_prod[mcis_pkg::K_W-1:0];
                end
                n_rem = div_ge ? div_s[mcis_pkg::BLK_W-1:0] : div_t[mcis_pkg::BLK_W-1:0];
                n_quo = {r_quo[mcis_pkg::DIM_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    if (r_state == mcis_pkg::S_DIVX) begin
                        n_qx    = {r_quo[mcis_pkg::DIM_W-2:0], div_ge};
                        n_quo   = r_bh;
                        n_rem   = '0;
                        n_state = mcis_pkg::S_DIVY;
                    end else begin
                        n_qy    = {r_quo[mcis_pkg::DIM_W-2:0], div_ge};
                        n_lvl   = '0;
                        n_acc   = '0;
                        n_pend  = 1'b0;
                        n_state = mcis_pkg::S_DIMS;
                    end
                end
            end

            mcis_pkg::S_DIMS: begin
                n_acc  = acc_sum;
                n_pend = 1'b0;
                if (r_lvl == r_levels) begin
                    // wait here only while the last result is still unread
                    if (!r_ovld || o_out.ready) begin
                        n_total = acc_sat;
                        n_ovld  = 1'b1;
                        n_state = mcis_pkg::S_IDLE;
                    end
                end else if (r_lvl >= mcis_pkg::LVL_W'(mcis_pkg::LVL_LOOP)) begin
                    n_state = mcis_pkg::S_TAIL;
                end else begin
                    n_nx    = x_blk;
                    n_ny    = y_blk;
                    n_state = mcis_pkg::S_MXY;
                end
            end

            mcis_pkg::S_MXY: begin
                n_prod  = mul_p;
                n_state = mcis_pkg::S_MTERM;
            end

            mcis_pkg::S_MTERM: begin
                n_prod  = mul_p;
                n_pend  = 1'b1;
                n_lvl   = r_lvl + 1'b1;
                n_state = mcis_pkg::S_DIMS;
            end

            mcis_pkg::S_TAIL: begin
                // every remaining level is one block: k times the level count
                n_prod  = mul_p;
                n_pend  = 1'b1;
                n_lvl   = r_levels;
                n_state = mcis_pkg::S_DIMS;
            end

            default: begin
                n_state = mcis_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcis_pkg::S_IDLE;
            r_cnt   <= '0;
            r_lvl   <= '0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lvl   <= n_lvl;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_bw     <= n_bw;
        r_bh     <= n_bh;
        r_levels <= n_levels;
        r_layers <= n_layers;
        r_blkw   <= n_blkw;
        r_blkh   <= n_blkh;
        r_bytes  <= n_bytes;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_k      <= n_k;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_total  <= n_total;
    end

`ifndef ASSERT_OFF
    // a taken request always starts with the layers*bytes multiply
    a_start_kmul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == mcis_pkg::S_KMUL))
        else $error("request not followed by k multiply");

    // width division hands over to height division after the last bit
    a_div_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcis_pkg::S_DIVX && r_cnt == '1) |=> (r_state == mcis_pkg::S_DIVY))
        else $error("width division did not hand over");

    // a pending product is only ever added in the level setup state
    a_pend_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == mcis_pkg::S_DIMS))
        else $error("pending product outside level setup");

    // the per-level loop never runs past the 1x1 tail point
    a_loop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcis_pkg::S_MXY) |->
            (r_lvl < mcis_pkg::LVL_W'(mcis_pkg::LVL_LOOP) && r_lvl < r_levels))
        else $error("level loop out of range");

    // the level counter never overshoots the requested count
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcis_pkg::S_DIMS) |-> (r_lvl <= r_levels))
        else $error("level counter overshoot");
`endif

endmodule
